// File: rtl/core/dcd_pkg.sv
// ----------------------------------------------------------------------------
// dcd_pkg
// Types, widths and constants shared by the day countdown block and its
// channels: payload structs, ASCII codes, month offsets, reciprocal constants
// ----------------------------------------------------------------------------
package dcd_pkg;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DIFF_W  = 17;
    localparam int CHAR_W  = 8;

    localparam int EPOCH_YEAR  = 2000;
    localparam int EPOCH_LEAPS = (EPOCH_YEAR - 1) / 4 - (EPOCH_YEAR - 1) / 100
                               + (EPOCH_YEAR - 1) / 400;

    localparam int DAYNUM_W  = 21;
    localparam int MSTART_W  = 9;
    localparam int Q100_W    = 6;
    localparam int ABS_W     = DIFF_W;
    localparam int Q1000_W   = 7;
    localparam int REM_W     = 10;
    localparam int DIGIT_W   = 4;

    localparam int DIFF_MAX = 65535;
    localparam int DIFF_MIN = -65536;

    // floor(v / 100) for v below 4096
    localparam int                 RECIP100_W     = 13;
    localparam logic [RECIP100_W-1:0] RECIP100    = 13'd5243;
    localparam int                 RECIP100_SHIFT = 19;

    // floor(a / 1000) for a up to 65536
    localparam logic [ABS_W-1:0]   RECIP1000       = 17'd67109;
    localparam int                 RECIP1000_SHIFT = 26;

    // digit split of a remainder below 1024
    localparam int                 DIG100_MUL   = 41;
    localparam int                 DIG100_SHIFT = 12;
    localparam int                 DIG10_MUL    = 205;
    localparam int                 DIG10_SHIFT  = 11;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_D     = 8'h44;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_Y     = 8'h59;

    typedef struct packed {
        logic [YEAR_W-1:0]  today_year;
        logic [MONTH_W-1:0] today_month;
        logic [DAY_W-1:0]   today_day;
        logic [YEAR_W-1:0]  target_year;
        logic [MONTH_W-1:0] target_month;
        logic [DAY_W-1:0]   target_day;
    } dcd_in_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] days_difference;
        logic [CHAR_W-1:0]        sign_char;
        logic [CHAR_W-1:0]        hundreds_char;
        logic [CHAR_W-1:0]        tens_char;
        logic [CHAR_W-1:0]        ones_char;
    } dcd_out_t;

    // days before the month in a common year, a full year past december
    function automatic logic [MSTART_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [MSTART_W-1:0] days;
        case (m)
            4'd0, 4'd1: days = 9'd0;
            4'd2:       days = 9'd31;
            4'd3:       days = 9'd59;
            4'd4:       days = 9'd90;
            4'd5:       days = 9'd120;
            4'd6:       days = 9'd151;
            4'd7:       days = 9'd181;
            4'd8:       days = 9'd212;
            4'd9:       days = 9'd243;
            4'd10:      days = 9'd273;
            4'd11:      days = 9'd304;
            4'd12:      days = 9'd334;
            default:    days = 9'd365;
        endcase
        return days;
    endfunction

endpackage

// File: rtl/core/dcd_stream_if.sv
// ----------------------------------------------------------------------------
// dcd_stream_if
// Valid/ready channel with a typed payload; one transfer per cycle at most
// ----------------------------------------------------------------------------
interface dcd_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

// File: rtl/core/day_countdown_from_dates.sv
// ----------------------------------------------------------------------------
// day_countdown_from_dates
// Gregorian day numbers of two dates, their signed difference and the
// four characters of a countdown message
//
//   channel     dir   payload     transfer when
//   dates       in    dcd_in_t    dates.valid && dates.ready
//   countdown   out   dcd_out_t   countdown.valid && countdown.ready
//
// six register stages: date split, day number, difference, thousands
// quotient, remainder, characters; one transfer per cycle while countdown is ready
// reset clears only the stage valid bits
// a stall holds each full stage with no empty stage ahead of it; empty stages keep filling behind it
// ----------------------------------------------------------------------------
module day_countdown_from_dates (
    input  logic          clk,
    input  logic          rst_n,
    dcd_stream_if.sink    dates,
    dcd_stream_if.source  countdown
);

    import dcd_pkg::*;

    localparam int NSTAGE    = 6;
    localparam int PROD100_W = YEAR_W + RECIP100_W;
    localparam int PROD1K_W  = 2 * ABS_W;
    localparam int PH_W      = REM_W + 6;
    localparam int PT_W      = REM_W + 8;

    typedef struct packed {
        logic                  in_range;
        logic [YEAR_W-1:0]     span;
        logic [YEAR_W-3:0]     ym1_q4;
        logic [Q100_W-1:0]     q100_y;
        logic [Q100_W-1:0]     q100_ym1;
        logic                  y_mult4;
        logic [MSTART_W-1:0]   mstart;
        logic                  past_feb;
        logic [DAY_W-1:0]      day;
    } date_front_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] diff;
        logic                     nonpos;
    } diff_info_t;

    typedef struct packed {
        logic zero;
        logic lt10;
        logic lt100;
    } digit_flags_t;

    function automatic date_front_t date_front(
        input logic [YEAR_W-1:0]  y,
        input logic [MONTH_W-1:0] m,
        input logic [DAY_W-1:0]   d
    );
        logic [YEAR_W-1:0]    ym1;
        logic [PROD100_W-1:0] prod_y;
        logic [PROD100_W-1:0] prod_ym1;
        date_front_t          f;
        ym1        = y - YEAR_W'(1);
        prod_y     = PROD100_W'(y) * PROD100_W'(RECIP100);
        prod_ym1   = PROD100_W'(ym1) * PROD100_W'(RECIP100);
        f.in_range = (y >= YEAR_W'(EPOCH_YEAR));
        f.span     = y - YEAR_W'(EPOCH_YEAR);
        f.ym1_q4   = ym1[YEAR_W-1:2];
        f.q100_y   = Q100_W'(prod_y >> RECIP100_SHIFT);
        f.q100_ym1 = Q100_W'(prod_ym1 >> RECIP100_SHIFT);
        f.y_mult4  = (y[1:0] == 2'b00);
        f.mstart   = month_start(m);
        f.past_feb = (m >= MONTH_W'(3));
        f.day      = d;
        return f;
    endfunction

    function automatic logic [DAYNUM_W-1:0] day_number(input date_front_t f);
        logic                leap;
        logic [DAYNUM_W-1:0] n;
        leap = f.y_mult4 && ((f.q100_y == f.q100_ym1) || (f.q100_y[1:0] == 2'b00));
        n = DAYNUM_W'(f.span) * DAYNUM_W'(365)
          + DAYNUM_W'(f.ym1_q4) - DAYNUM_W'(f.q100_ym1) + DAYNUM_W'(f.q100_ym1 >> 2)
          - DAYNUM_W'(EPOCH_LEAPS)
          + DAYNUM_W'(f.mstart) + DAYNUM_W'(leap && f.past_feb) + DAYNUM_W'(f.day);
        return f.in_range ? n : '0;
    endfunction

    logic [NSTAGE-1:0]   valid_reg;
    logic [NSTAGE-1:0]   valid_next;
    logic [NSTAGE-1:0]   adv;

    date_front_t         front_today_reg;
    date_front_t         front_target_reg;
    logic [DAYNUM_W-1:0] dn_today_reg;
    logic [DAYNUM_W-1:0] dn_target_reg;
    diff_info_t          info2_reg;
    logic [ABS_W-1:0]    abs2_reg;
    diff_info_t          info3_reg;
    logic [ABS_W-1:0]    abs3_reg;
    logic [Q1000_W-1:0]  q1000_reg;
    digit_flags_t        flags3_reg;
    diff_info_t          info4_reg;
    digit_flags_t        flags4_reg;
    logic [REM_W-1:0]    rem_reg;
    dcd_out_t            out_reg;

    // handshake chain
    always_comb
    begin
        adv[NSTAGE-1] = !valid_reg[NSTAGE-1] || countdown.ready;
        for (int i = NSTAGE - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = dates.valid;
        end
        for (int i = 1; i < NSTAGE; i++)
        begin
            if (adv[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign dates.ready     = adv[0];
    assign countdown.valid = valid_reg[NSTAGE-1];
    assign countdown.data  = out_reg;

    // difference, saturation and magnitude
    logic signed [DAYNUM_W:0]  diff_wide;
    logic signed [DIFF_W-1:0]  diff_sat;
    logic [DIFF_W:0]           diff_ext;
    logic [DIFF_W:0]           diff_mag;
    diff_info_t                info2_next;
    logic [ABS_W-1:0]          abs2_next;

    always_comb
    begin
        diff_wide = $signed({1'b0, dn_today_reg}) - $signed({1'b0, dn_target_reg});
        if (diff_wide > DIFF_MAX)
        begin
            diff_sat = DIFF_W'(DIFF_MAX);
        end
        else if (diff_wide < DIFF_MIN)
        begin
            diff_sat = DIFF_W'(DIFF_MIN);
        end
        else
        begin
            diff_sat = diff_wide[DIFF_W-1:0];
        end
        diff_ext          = {diff_sat[DIFF_W-1], diff_sat};
        diff_mag          = diff_ext[DIFF_W] ? (~diff_ext + (DIFF_W+1)'(1)) : diff_ext;
        abs2_next         = diff_mag[ABS_W-1:0];
        info2_next.diff   = diff_sat;
        info2_next.nonpos = diff_sat[DIFF_W-1] || (diff_sat == '0);
    end

    // thousands quotient and digit flags
    logic [PROD1K_W-1:0] prod1k;
    logic [Q1000_W-1:0]  q1000_next;
    digit_flags_t        flags3_next;

    always_comb
    begin
        prod1k            = PROD1K_W'(abs2_reg) * PROD1K_W'(RECIP1000);
        q1000_next        = Q1000_W'(prod1k >> RECIP1000_SHIFT);
        flags3_next.zero  = (abs2_reg == '0);
        flags3_next.lt10  = (abs2_reg < ABS_W'(10));
        flags3_next.lt100 = (abs2_reg < ABS_W'(100));
    end

    // last three digits
    logic [ABS_W-1:0] rem_full;
    logic [REM_W-1:0] rem_next;

    always_comb
    begin
        rem_full = abs3_reg - ABS_W'(q1000_reg) * ABS_W'(1000);
        rem_next = rem_full[REM_W-1:0];
    end

    // digit split and characters
    logic [PH_W-1:0]    prod_h;
    logic [PT_W-1:0]    prod_t;
    logic [DIGIT_W-1:0] dig_h;
    logic [6:0]         rem_div10;
    logic [DIGIT_W-1:0] dig_t;
    logic [DIGIT_W-1:0] dig_o;
    dcd_out_t           out_next;

    always_comb
    begin
        prod_h    = PH_W'(rem_reg) * PH_W'(DIG100_MUL);
        prod_t    = PT_W'(rem_reg) * PT_W'(DIG10_MUL);
        dig_h     = DIGIT_W'(prod_h >> DIG100_SHIFT);
        rem_div10 = 7'(prod_t >> DIG10_SHIFT);
        dig_t     = DIGIT_W'(rem_div10 - 7'(dig_h) * 7'(10));
        dig_o     = DIGIT_W'(rem_reg - REM_W'(rem_div10) * REM_W'(10));

        out_next.days_difference = info4_reg.diff;
        out_next.sign_char       = info4_reg.nonpos ? CH_MINUS : CH_DOT;
        if (flags4_reg.zero)
        begin
            out_next.hundreds_char = CH_D;
            out_next.tens_char     = CH_A;
            out_next.ones_char     = CH_Y;
        end
        else
        begin
            out_next.hundreds_char = flags4_reg.lt100 ? CH_SPACE
                                                      : CH_ZERO + CHAR_W'(dig_h);
            out_next.tens_char     = flags4_reg.lt10 ? CH_SPACE
                                                     : CH_ZERO + CHAR_W'(dig_t);
            out_next.ones_char     = CH_ZERO + CHAR_W'(dig_o);
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            front_today_reg  <= date_front(dates.data.today_year, dates.data.today_month,
                                           dates.data.today_day);
            front_target_reg <= date_front(dates.data.target_year, dates.data.target_month,
                                           dates.data.target_day);
        end
        if (adv[1])
        begin
            dn_today_reg  <= day_number(front_today_reg);
            dn_target_reg <= day_number(front_target_reg);
        end
        if (adv[2])
        begin
            info2_reg <= info2_next;
            abs2_reg  <= abs2_next;
        end
        if (adv[3])
        begin
            info3_reg  <= info2_reg;
            abs3_reg   <= abs2_reg;
            q1000_reg  <= q1000_next;
            flags3_reg <= flags3_next;
        end
        if (adv[4])
        begin
            info4_reg  <= info3_reg;
            flags4_reg <= flags3_reg;
            rem_reg    <= rem_next;
        end
        if (adv[5])
        begin
            out_reg <= out_next;
        end
    end

    // checks
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        countdown.ready |-> dates.ready)
        else $error("input stalled while output is ready");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[4] |-> (rem_reg < REM_W'(1000)))
        else $error("remainder out of range");

    a_zero_word: assert property (@(posedge clk) disable iff (!rst_n)
        (countdown.valid && (countdown.data.days_difference == '0)) |->
        ((countdown.data.hundreds_char == CH_D) && (countdown.data.tens_char == CH_A)
         && (countdown.data.ones_char == CH_Y) && (countdown.data.sign_char == CH_MINUS)))
        else $error("zero difference without day word");

    a_pos_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (countdown.valid && !countdown.data.days_difference[DIFF_W-1]
         && (countdown.data.days_difference != '0)) |->
        (countdown.data.sign_char == CH_DOT))
        else $error("positive difference with wrong sign character");

endmodule

// File: verif/day_countdown_from_dates_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// day_countdown_from_dates_tb
// Self-checking bench for the day countdown block. Date pairs go in on the
// dates channel; an in-bench predictor works out the day difference, its
// saturation and the four countdown characters for every accepted transfer,
// and each countdown transfer is checked field by field in order. Directed
// corner dates come first, then random date pairs with idling on both
// channels, a run with no idling, a long output stall and a last idling run.
// ----------------------------------------------------------------------------
module day_countdown_from_dates_tb;

    import dcd_pkg::*;

    localparam int PIPE_LATENCY = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int STALL_CYCLES = 300;

    // days before each month in a common year, a full year past december
    localparam int DAYS_BEFORE_MONTH [14] = '{
        0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365
    };

    logic clk = 1'b0;
    logic rst_n;

    dcd_stream_if #(.payload_t(dcd_in_t))  dates_ch ();
    dcd_stream_if #(.payload_t(dcd_out_t)) countdown_ch ();

    day_countdown_from_dates dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .dates     (dates_ch.sink),
        .countdown (countdown_ch.source)
    );

    dcd_out_t pending_countdowns [$];

    int  cycle_count       = 0;
    int  mismatch_count    = 0;
    int  accepted_dates    = 0;
    int  checked_countdown = 0;
    int  day_of_count      = 0;
    int  saturated_count   = 0;
    int  stall_requests    = 0;
    bit  src_idle_on       = 1'b1;
    bit  snk_idle_on       = 1'b1;

    always #1 clk = ~clk;

    // day predictor

    function automatic int leaps_through(input int n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    function automatic bit year_has_leap_day(input int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int day_index(input logic [YEAR_W-1:0] year,
                                     input logic [MONTH_W-1:0] month,
                                     input logic [DAY_W-1:0] day);
        int y;
        int m;
        int n;
        y = int'(year);
        m = (int'(month) > 13) ? 13 : int'(month);
        if (y < EPOCH_YEAR)
            return 0;
        n = 365 * (y - EPOCH_YEAR) + leaps_through(y - 1) - leaps_through(EPOCH_YEAR - 1);
        n += DAYS_BEFORE_MONTH[m];
        if (m >= 3 && year_has_leap_day(y))
            n += 1;
        return n + int'(day);
    endfunction

    function automatic dcd_out_t predict_countdown(input dcd_in_t d);
        dcd_out_t r;
        int diff;
        int mag;
        diff = day_index(d.today_year, d.today_month, d.today_day)
             - day_index(d.target_year, d.target_month, d.target_day);
        if (diff > DIFF_MAX)
            diff = DIFF_MAX;
        if (diff < DIFF_MIN)
            diff = DIFF_MIN;
        mag = (diff < 0) ? -diff : diff;
        r.days_difference = diff[DIFF_W-1:0];
        r.sign_char = (diff <= 0) ? CH_MINUS : CH_DOT;
        if (mag == 0)
        begin
            r.hundreds_char = CH_D;
            r.tens_char     = CH_A;
            r.ones_char     = CH_Y;
        end
        else
        begin
            r.hundreds_char = (mag < 100) ? CH_SPACE : CHAR_W'(CH_ZERO + (mag / 100) % 10);
            r.tens_char     = (mag < 10) ? CH_SPACE : CHAR_W'(CH_ZERO + (mag / 10) % 10);
            r.ones_char     = CHAR_W'(CH_ZERO + mag % 10);
        end
        return r;
    endfunction

    // channel processes

    always @(posedge clk)
    begin
        if (dates_ch.valid && dates_ch.ready)
        begin
            pending_countdowns.push_back(predict_countdown(dates_ch.data));
            accepted_dates++;
        end
    end

    function automatic void check_field(input string name, input int exp_val,
                                        input int act_val);
        if (exp_val !== act_val)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
                     $time, name, exp_val, exp_val, act_val, act_val);
        end
    endfunction

    always @(posedge clk)
    begin
        dcd_out_t exp_cd;
        dcd_out_t act_cd;
        if (countdown_ch.valid && countdown_ch.ready)
        begin
            act_cd = countdown_ch.data;
            if (pending_countdowns.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: countdown transfer with nothing expected, actual %0d",
                         $time, act_cd.days_difference);
            end
            else
            begin
                exp_cd = pending_countdowns.pop_front();
                check_field("days_difference", int'(exp_cd.days_difference),
                            int'(act_cd.days_difference));
                check_field("sign_char", int'(exp_cd.sign_char), int'(act_cd.sign_char));
                check_field("hundreds_char", int'(exp_cd.hundreds_char),
                            int'(act_cd.hundreds_char));
                check_field("tens_char", int'(exp_cd.tens_char), int'(act_cd.tens_char));
                check_field("ones_char", int'(exp_cd.ones_char), int'(act_cd.ones_char));
                checked_countdown++;
                if (exp_cd.hundreds_char == CH_D)
                    day_of_count++;
                if (exp_cd.days_difference == DIFF_MAX[DIFF_W-1:0]
                    || exp_cd.days_difference == DIFF_MIN[DIFF_W-1:0])
                    saturated_count++;
            end
        end
    end

    initial
    begin
        int hold_left;
        int stalls_done;
        hold_left   = 0;
        stalls_done = 0;
        countdown_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stalls_done != stall_requests)
            begin
                stalls_done = stall_requests;
                hold_left   = STALL_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                countdown_ch.ready <= 1'b0;
            end
            else
                countdown_ch.ready <= !(snk_idle_on && $urandom_range(0, 99) < 10);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d countdowns outstanding",
                     $time, cycle_count, pending_countdowns.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // stimulus

    function automatic dcd_in_t pack_dates(input int ty, input int tm, input int td,
                                           input int gy, input int gm, input int gd);
        dcd_in_t d;
        d.today_year   = YEAR_W'(ty);
        d.today_month  = MONTH_W'(tm);
        d.today_day    = DAY_W'(td);
        d.target_year  = YEAR_W'(gy);
        d.target_month = MONTH_W'(gm);
        d.target_day   = DAY_W'(gd);
        return d;
    endfunction

    function automatic dcd_in_t random_dates();
        dcd_in_t d;
        int pick;
        int m;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            // plausible dates anywhere in the century
            d = pack_dates($urandom_range(2000, 2099), $urandom_range(1, 12),
                           $urandom_range(1, 31), $urandom_range(2000, 2099),
                           $urandom_range(1, 12), $urandom_range(1, 31));
        end
        else if (pick < 75)
        begin
            // target close to today, small countdowns
            d = pack_dates($urandom_range(2000, 2099), $urandom_range(1, 12),
                           $urandom_range(1, 31), 0, 0, 0);
            m = int'(d.today_month) + $urandom_range(0, 2) - 1;
            d.target_year  = d.today_year;
            d.target_month = MONTH_W'((m < 1) ? 1 : (m > 12) ? 12 : m);
            d.target_day   = DAY_W'($urandom_range(1, 31));
        end
        else if (pick < 80)
        begin
            d = pack_dates($urandom_range(2000, 2099), $urandom_range(1, 12),
                           $urandom_range(1, 31), 0, 0, 0);
            d.target_year  = d.today_year;
            d.target_month = d.today_month;
            d.target_day   = d.today_day;
        end
        else
            d = dcd_in_t'($bits(dcd_in_t)'({$urandom, $urandom}));
        return d;
    endfunction

    task automatic send_dates(input dcd_in_t item);
        int gap;
        if (src_idle_on && $urandom_range(0, 99) < 4)
        begin
            gap = $urandom_range(1, 4);
            dates_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        dates_ch.valid <= 1'b1;
        dates_ch.data  <= item;
        do
            @(posedge clk);
        while (!dates_ch.ready);
    endtask

    task automatic test_directed();
        send_dates(pack_dates(2000, 1, 1, 2000, 1, 1));
        send_dates(pack_dates(2000, 1, 2, 2000, 1, 1));
        send_dates(pack_dates(2000, 1, 1, 2000, 1, 11));
        send_dates(pack_dates(2000, 4, 10, 2000, 1, 1));
        send_dates(pack_dates(2000, 4, 15, 2000, 1, 1));
        send_dates(pack_dates(2002, 9, 27, 2000, 1, 1));
        send_dates(pack_dates(1999, 12, 31, 0, 0, 0));
        send_dates(pack_dates(0, 15, 31, 2000, 1, 1));
        send_dates(pack_dates(2010, 0, 5, 2010, 1, 5));
        send_dates(pack_dates(2010, 13, 0, 2010, 15, 0));
        send_dates(pack_dates(2011, 14, 31, 2012, 1, 0));
        send_dates(pack_dates(2000, 3, 1, 2000, 2, 28));
        send_dates(pack_dates(2100, 3, 1, 2100, 2, 28));
        send_dates(pack_dates(2400, 3, 1, 2400, 2, 28));
        send_dates(pack_dates(2024, 2, 31, 2024, 3, 0));
        send_dates(pack_dates(4095, 15, 31, 0, 0, 0));
        send_dates(pack_dates(0, 0, 0, 4095, 15, 31));
        send_dates(pack_dates(2099, 12, 31, 2000, 1, 1));
        send_dates(pack_dates(2000, 1, 1, 2099, 12, 31));
        send_dates(pack_dates(2179, 7, 16, 2000, 1, 1));
    endtask

    task automatic test_random_idle(input int count);
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        repeat (count) send_dates(random_dates());
    endtask

    task automatic test_no_idle(input int count);
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        repeat (count) send_dates(random_dates());
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
    endtask

    task automatic test_output_stall(input int count);
        // output held off long enough for the pipe to fill and stall dates
        stall_requests++;
        repeat (count) send_dates(random_dates());
    endtask

    initial
    begin
        rst_n <= 1'b0;
        dates_ch.valid <= 1'b0;
        dates_ch.data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_idle(900);
        test_no_idle(250);
        test_output_stall(80);
        test_random_idle(250);

        dates_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_countdowns.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);

        $display("covered %0d date pairs, %0d countdowns checked", accepted_dates,
                 checked_countdown);
        $display("of those %0d day-of results and %0d saturated differences",
                 day_of_count, saturated_count);
        if (mismatch_count == 0 && pending_countdowns.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
rtl/core/dcd_pkg.sv
rtl/core/dcd_stream_if.sv
rtl/core/day_countdown_from_dates.sv
verif/day_countdown_from_dates_tb.sv
